// ===== rtl/sha1md_pkg.sv =====
package sha1md_pkg;

  localparam int unsigned NUM_CHAIN = 5;
  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned NUM_ROUNDS = 80;

  localparam logic [NUM_CHAIN-1:0][31:0] CHAIN_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // block source selection for one compression
  localparam logic [1:0] MODE_NORMAL = 2'd0; // all sixteen words from memory
  localparam logic [1:0] MODE_PAD1 = 2'd1;   // held bytes, 0x80, zeros, length if room
  localparam logic [1:0] MODE_PAD2 = 2'd2;   // zeros and length only

  typedef struct packed {
    logic start;
    logic chain_init;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  fill;
    logic [63:0] bits;
  } pad_t;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd inside {[7'd40:7'd59]}) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ===== rtl/sha1_message_digest.sv =====
// Channel   Dir  Handshake              Beat payload
// in_       in   in_valid / in_stall    in_data_byte, in_has_byte, in_last
// out_      out  out_valid / out_stall  out_digest_word_0 .. out_digest_word_4
//
// A beat that does not complete a 64-byte block is taken without a stall; one that does
// holds in_stall through a fetch, 80 rounds at one per cycle and a chain add.
// A last beat adds those steps per padding block (two when 56 or more bytes are held),
// then an emit state that loads the digest into the output register.
// rst_n is synchronous; it restores the initial chain and clears counts.
// in_stall also stays high while a finished digest waits behind a stalled output beat.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word_0,
  output logic [31:0] out_digest_word_1,
  output logic [31:0] out_digest_word_2,
  output logic [31:0] out_digest_word_3,
  output logic [31:0] out_digest_word_4
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GO = 3'd1;
  localparam logic [2:0] ST_RUN = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [2:0]  state_r;
  logic [1:0]  mode_r;
  logic        pend_last_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic        out_valid_r;
  logic [sha1md_pkg::NUM_CHAIN-1:0][31:0] digest_r;

  logic        in_acc;
  logic        byte_we;
  logic        emit;
  logic        core_done;
  logic [6:0]  core_rnd;
  logic [6:0]  rnd_inc;
  logic [3:0]  rd_idx;
  logic [31:0] blk_word;
  logic [sha1md_pkg::NUM_CHAIN-1:0][31:0] chain;
  sha1md_pkg::cmd_t cmd;
  sha1md_pkg::pad_t pad;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign byte_we = in_acc && in_has_byte;
  assign emit = (state_r == ST_EMIT) && !(out_valid_r && out_stall);

  assign rnd_inc = core_rnd + 7'd1;
  assign rd_idx = (state_r == ST_GO) ? 4'd0 : rnd_inc[3:0];

  assign cmd.start = (state_r == ST_GO);
  assign cmd.chain_init = emit;
  assign pad.mode = mode_r;
  assign pad.fill = fill_r;
  assign pad.bits = bits_r;

  sha1md_buf u_buf (
    .clk       (clk),
    .byte_we   (byte_we),
    .data_byte (in_data_byte),
    .pad       (pad),
    .rd_idx    (rd_idx),
    .blk_word  (blk_word)
  );

  sha1md_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .w_word (blk_word),
    .done   (core_done),
    .rnd    (core_rnd),
    .chain  (chain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r <= sha1md_pkg::MODE_NORMAL;
      pend_last_r <= 1'b0;
      fill_r <= 6'd0;
      bits_r <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_has_byte) begin
              fill_r <= fill_r + 6'd1;
              bits_r <= bits_r + 64'd8;
            end
            pend_last_r <= in_last;
            if (in_has_byte && fill_r == 6'd63) begin
              mode_r <= sha1md_pkg::MODE_NORMAL;
              state_r <= ST_GO;
            end else if (in_last) begin
              mode_r <= sha1md_pkg::MODE_PAD1;
              state_r <= ST_GO;
            end
          end
        end
        ST_GO: state_r <= ST_RUN;
        ST_RUN: begin
          if (core_done) begin
            case (mode_r)
              sha1md_pkg::MODE_NORMAL: begin
                if (pend_last_r) begin
                  mode_r <= sha1md_pkg::MODE_PAD1;
                  state_r <= ST_GO;
                end else begin
                  state_r <= ST_IDLE;
                end
              end
              sha1md_pkg::MODE_PAD1: begin
                if (fill_r >= 6'd56) begin
                  mode_r <= sha1md_pkg::MODE_PAD2;
                  state_r <= ST_GO;
                end else begin
                  state_r <= ST_EMIT;
                end
              end
              default: state_r <= ST_EMIT;
            endcase
          end
        end
        ST_EMIT: begin
          if (emit) begin
            fill_r <= 6'd0;
            bits_r <= 64'd0;
            pend_last_r <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      digest_r <= chain;
    end
  end

  assign out_valid = out_valid_r;
  assign out_digest_word_0 = digest_r[0];
  assign out_digest_word_1 = digest_r[1];
  assign out_digest_word_2 = digest_r[2];
  assign out_digest_word_3 = digest_r[3];
  assign out_digest_word_4 = digest_r[4];

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> state_r == ST_RUN)
    else $error("round unit finished outside a compression");

  a_pad2_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && mode_r == sha1md_pkg::MODE_PAD2) |-> fill_r >= 6'd56)
    else $error("length-only block without a full first padding block");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (fill_r == 6'd0 && bits_r == 64'd0 && out_valid_r))
    else $error("message counters not cleared after digest");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GO || state_r == ST_RUN) |=> $stable(bits_r))
    else $error("bit count moved during compression");

endmodule

// ===== rtl/sha1md_buf.sv =====
module sha1md_buf (
  input  logic               clk,
  input  logic               byte_we,
  input  logic [7:0]         data_byte,
  input  sha1md_pkg::pad_t   pad,
  input  logic [3:0]         rd_idx,
  output logic [31:0]        blk_word
);

  logic [31:0] mem [sha1md_pkg::NUM_WORDS];
  logic [31:0] mem_q_r;
  logic [3:0]  idx_q_r;
  logic [31:0] word_r;
  logic [31:0] word_nxt;
  logic [31:0] pad_word;
  logic [3:0]  wi;

  assign word_nxt = {word_r[23:0], data_byte};
  assign wi = pad.fill[5:2];

  always_ff @(posedge clk) begin
    if (byte_we) begin
      word_r <= word_nxt;
      if (pad.fill[1:0] == 2'b11) begin
        mem[pad.fill[5:2]] <= word_nxt;
      end
    end
    mem_q_r <= mem[rd_idx];
    idx_q_r <= rd_idx;
  end

  // partial word: held bytes, then the 0x80 marker, then zeros
  always_comb begin
    case (pad.fill[1:0])
      2'd0:    pad_word = {sha1md_pkg::PAD_BYTE, 24'h0};
      2'd1:    pad_word = {word_r[7:0], sha1md_pkg::PAD_BYTE, 16'h0};
      2'd2:    pad_word = {word_r[15:0], sha1md_pkg::PAD_BYTE, 8'h0};
      default: pad_word = {word_r[23:0], sha1md_pkg::PAD_BYTE};
    endcase
  end

  always_comb begin
    blk_word = 32'h0;
    case (pad.mode)
      sha1md_pkg::MODE_NORMAL: blk_word = mem_q_r;
      sha1md_pkg::MODE_PAD1: begin
        if (idx_q_r < wi) begin
          blk_word = mem_q_r;
        end else if (idx_q_r == wi) begin
          blk_word = pad_word;
        end else if (pad.fill < 6'd56 && idx_q_r == 4'd14) begin
          blk_word = pad.bits[63:32];
        end else if (pad.fill < 6'd56 && idx_q_r == 4'd15) begin
          blk_word = pad.bits[31:0];
        end else begin
          blk_word = 32'h0;
        end
      end
      sha1md_pkg::MODE_PAD2: begin
        if (idx_q_r == 4'd14) begin
          blk_word = pad.bits[63:32];
        end else if (idx_q_r == 4'd15) begin
          blk_word = pad.bits[31:0];
        end else begin
          blk_word = 32'h0;
        end
      end
      default: blk_word = 32'h0;
    endcase
  end

endmodule

// ===== rtl/sha1md_core.sv =====
module sha1md_core (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  sha1md_pkg::cmd_t                          cmd,
  input  logic [31:0]                               w_word,
  output logic                                      done,
  output logic [6:0]                                rnd,
  output logic [sha1md_pkg::NUM_CHAIN-1:0][31:0]    chain
);

  localparam logic [1:0] CS_IDLE = 2'd0;
  localparam logic [1:0] CS_RUN = 2'd1;
  localparam logic [1:0] CS_FIN = 2'd2;

  logic [1:0]  st_r;
  logic [6:0]  rnd_r;
  logic [sha1md_pkg::NUM_CHAIN-1:0][31:0] chain_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] sched_r [sha1md_pkg::NUM_WORDS];
  logic [31:0] w_x;
  logic [31:0] w_t;
  logic [31:0] t_sum;

  // sched_r[0] is W[t-1], sched_r[15] is W[t-16]
  assign w_x = sched_r[2] ^ sched_r[7] ^ sched_r[13] ^ sched_r[15];
  assign w_t = (rnd_r < 7'd16) ? w_word : {w_x[30:0], w_x[31]};
  assign t_sum = {a_r[26:0], a_r[31:27]} + sha1md_pkg::round_f(rnd_r, b_r, c_r, d_r)
               + e_r + sha1md_pkg::round_k(rnd_r) + w_t;

  assign done = (st_r == CS_FIN);
  assign rnd = rnd_r;
  assign chain = chain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CS_IDLE;
      rnd_r <= 7'd0;
      chain_r <= sha1md_pkg::CHAIN_INIT;
    end else begin
      case (st_r)
        CS_IDLE: begin
          if (cmd.chain_init) begin
            chain_r <= sha1md_pkg::CHAIN_INIT;
          end
          if (cmd.start) begin
            rnd_r <= 7'd0;
            st_r <= CS_RUN;
          end
        end
        CS_RUN: begin
          if (rnd_r == 7'(sha1md_pkg::NUM_ROUNDS - 1)) begin
            st_r <= CS_FIN;
          end else begin
            rnd_r <= rnd_r + 7'd1;
          end
        end
        CS_FIN: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          chain_r[4] <= chain_r[4] + e_r;
          st_r <= CS_IDLE;
        end
        default: st_r <= CS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == CS_IDLE && cmd.start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (st_r == CS_RUN) begin
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      sched_r[0] <= w_t;
      for (int i = 1; i < sha1md_pkg::NUM_WORDS; i++) begin
        sched_r[i] <= sched_r[i-1];
      end
    end
  end

endmodule
